[hw/rtl/nvpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest VGA palette color - shared definitions
// Palette table, entry counts, widths and the types that travel along the
// chain of distance cells.
// ----------------------------------------------------------------------------
package nvpc_pkg;

	localparam int PALETTE_ENTRIES    = 16;
	localparam int BACKGROUND_ENTRIES = 8;
	localparam int TABLE_SIZE         = 16;

	localparam int PAL_COUNT = (PALETTE_ENTRIES > TABLE_SIZE) ? TABLE_SIZE : PALETTE_ENTRIES;
	localparam int BG_COUNT  = (BACKGROUND_ENTRIES > PAL_COUNT) ? PAL_COUNT : BACKGROUND_ENTRIES;

	localparam int IDX_W  = 4;
	localparam int CNT_W  = 5;
	localparam int COMP_W = 8;
	localparam int SQ_W   = 16;
	localparam int WT_W   = 10;
	localparam int PROD_W = 26;
	localparam int TERM_W = 18;
	localparam int DIST_W = 20;

	localparam logic [WT_W-1:0] RED_BASE  = WT_W'(512);
	localparam logic [WT_W-1:0] BLUE_BASE = WT_W'(767);

	localparam logic [23:0] PALETTE [TABLE_SIZE] = '{
		24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
		24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
		24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
		24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
	};

	typedef struct packed {
		logic [COMP_W-1:0] r;
		logic [COMP_W-1:0] g;
		logic [COMP_W-1:0] b;
		logic              bg;
	} nvpc_pix_t;

	typedef struct packed {
		logic [DIST_W-1:0] score;
		logic [IDX_W-1:0]  idx;
	} nvpc_best_t;

endpackage

[hw/rtl/nvpc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest VGA palette color - distance cell
// Compares one transaction with one palette entry over three stages and
// hands the pixel and the running best match on to the next cell.
// ----------------------------------------------------------------------------
module nvpc_cell
	import nvpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] entry_idx,
	input  logic             in_valid,
	input  nvpc_pix_t        in_pix,
	input  nvpc_best_t       in_best,
	output logic             out_valid,
	output nvpc_pix_t        out_pix,
	output nvpc_best_t       out_best
);

	logic [23:0]       pal;
	logic [COMP_W-1:0] pr, pg, pb;
	logic [COMP_W:0]   rsum;
	logic [COMP_W-1:0] dr, dg, db;

	logic              valid_s1, valid_s2, valid_s3;
	nvpc_pix_t         pix_s1, pix_s2, pix_s3;
	nvpc_best_t        best_s1, best_s2, best_s3;
	logic [SQ_W-1:0]   dr2_s1, dg2_s1, db2_s1;
	logic [COMP_W-1:0] mean_s1;

	logic [WT_W-1:0]   rw, bw;
	logic [PROD_W-1:0] rprod, bprod;
	logic [TERM_W-1:0] rterm_s2, gterm_s2, bterm_s2;

	logic [DIST_W-1:0] score;
	logic              enabled;

	assign pal  = PALETTE[entry_idx];
	assign pr   = pal[23:16];
	assign pg   = pal[15:8];
	assign pb   = pal[7:0];
	assign rsum = {1'b0, pr} + {1'b0, in_pix.r};
	assign dr   = (pr >= in_pix.r) ? (pr - in_pix.r) : (in_pix.r - pr);
	assign dg   = (pg >= in_pix.g) ? (pg - in_pix.g) : (in_pix.g - pg);
	assign db   = (pb >= in_pix.b) ? (pb - in_pix.b) : (in_pix.b - pb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1  <= in_pix;
		best_s1 <= in_best;
		mean_s1 <= rsum[COMP_W:1];
		dr2_s1  <= SQ_W'(dr) * SQ_W'(dr);
		dg2_s1  <= SQ_W'(dg) * SQ_W'(dg);
		db2_s1  <= SQ_W'(db) * SQ_W'(db);
	end

	assign rw    = RED_BASE + WT_W'(mean_s1);
	assign bw    = BLUE_BASE - WT_W'(mean_s1);
	assign rprod = PROD_W'(rw) * PROD_W'(dr2_s1);
	assign bprod = PROD_W'(bw) * PROD_W'(db2_s1);

	always_ff @(posedge clk) begin
		pix_s2   <= pix_s1;
		best_s2  <= best_s1;
		rterm_s2 <= rprod[PROD_W-1:8];
		gterm_s2 <= {dg2_s1, 2'b00};
		bterm_s2 <= bprod[PROD_W-1:8];
	end

	assign score   = DIST_W'(rterm_s2) + DIST_W'(gterm_s2) + DIST_W'(bterm_s2);
	assign enabled = !pix_s2.bg || ({1'b0, entry_idx} < CNT_W'(BG_COUNT));

	always_ff @(posedge clk) begin
		pix_s3 <= pix_s2;
		if (enabled && (score < best_s2.score)) begin
			best_s3.score <= score;
			best_s3.idx   <= entry_idx;
		end else begin
			best_s3 <= best_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_pix   = pix_s3;
	assign out_best  = best_s3;

endmodule

[hw/rtl/nearest_vga_palette_color.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest VGA palette color
// Finds the entry of the 16-color VGA palette that is closest to an RGB pixel
// under the weighted redmean distance.
// ----------------------------------------------------------------------------
// A new transaction is taken in every clock cycle; busy is always low. Each
// transaction gives one result on palette_index, marked by done for one cycle,
// after the pixel has passed a row of one three-stage distance cell per entry.
// The receiver cannot stall, so results must be taken as they appear. Ties go
// to the lower index, and background_only limits the search to the first
// eight entries.
// ----------------------------------------------------------------------------
module nearest_vga_palette_color
	import nvpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [23:0]      pixel_rgb,
	input  logic             background_only,
	output logic             done,
	output logic [IDX_W-1:0] palette_index
);

	logic       valid_c [PAL_COUNT+1];
	nvpc_pix_t  pix_c   [PAL_COUNT+1];
	nvpc_best_t best_c  [PAL_COUNT+1];

	assign busy = 1'b0;

	assign valid_c[0]      = start;
	assign pix_c[0].r      = pixel_rgb[23:16];
	assign pix_c[0].g      = pixel_rgb[15:8];
	assign pix_c[0].b      = pixel_rgb[7:0];
	assign pix_c[0].bg     = background_only;
	assign best_c[0].score = '1;
	assign best_c[0].idx   = '0;

	for (genvar i = 0; i < PAL_COUNT; i++) begin : g_cell
		nvpc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.entry_idx (IDX_W'(i)),
			.in_valid  (valid_c[i]),
			.in_pix    (pix_c[i]),
			.in_best   (best_c[i]),
			.out_valid (valid_c[i+1]),
			.out_pix   (pix_c[i+1]),
			.out_best  (best_c[i+1])
		);
	end

	assign done          = valid_c[PAL_COUNT];
	assign palette_index = best_c[PAL_COUNT].idx;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the nearest VGA palette color block
// Sends directed and random pixels in bursts with random gaps. A scoreboard
// predicts the nearest palette index under the redmean distance for every
// accepted transaction and checks each result in order as it appears.
// ----------------------------------------------------------------------------
module tb;
	import nvpc_pkg::*;

	localparam int RANDOM_PIXELS = 1500;
	localparam int IDLE_LIMIT    = 1000;
	localparam int DRAIN_CYCLES  = 64;

	typedef struct {
		logic [23:0]      pixel;
		logic             bg;
		logic [IDX_W-1:0] index;
	} palette_guess_t;

	class palette_scoreboard;
		int errors = 0;
		palette_guess_t expected_indices[$];
		logic [23:0] vga_colors [16] = '{
			24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
			24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
			24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
			24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
		};

		task report(input string msg);
			$display("%0t ns: %s", $realtime, msg);
			errors++;
		endtask

		function int unsigned abs_delta(input logic [7:0] a, input logic [7:0] b);
			int unsigned ua;
			int unsigned ub;
			ua = a;
			ub = b;
			return (ua >= ub) ? ua - ub : ub - ua;
		endfunction

		function logic [IDX_W-1:0] nearest_color(input logic [23:0] pix, input logic bg);
			int unsigned full_cnt;
			int unsigned back_cnt;
			int unsigned cnt;
			int unsigned best;
			int unsigned score;
			int unsigned mean;
			int unsigned dr;
			int unsigned dg;
			int unsigned db;
			int unsigned pr;
			logic [IDX_W-1:0] best_idx;
			full_cnt = (PALETTE_ENTRIES > 16) ? 16 : PALETTE_ENTRIES;
			back_cnt = (BACKGROUND_ENTRIES > full_cnt) ? full_cnt : BACKGROUND_ENTRIES;
			cnt = bg ? back_cnt : full_cnt;
			best = 32'hFFFF_FFFF;
			best_idx = '0;
			for (int i = 0; i < cnt; i++) begin
				pr = vga_colors[i][23:16];
				mean = (pr + pix[23:16]) >> 1;
				dr = abs_delta(vga_colors[i][23:16], pix[23:16]);
				dg = abs_delta(vga_colors[i][15:8], pix[15:8]);
				db = abs_delta(vga_colors[i][7:0], pix[7:0]);
				score = (((512 + mean) * dr * dr) >> 8) + 4 * dg * dg
					+ (((767 - mean) * db * db) >> 8);
				if (score < best) begin
					best = score;
					best_idx = IDX_W'(i);
				end
			end
			return best_idx;
		endfunction

		function void note_pixel(input logic [23:0] pix, input logic bg);
			palette_guess_t g;
			g.pixel = pix;
			g.bg = bg;
			g.index = nearest_color(pix, bg);
			expected_indices.push_back(g);
		endfunction

		task check_index(input logic [IDX_W-1:0] got);
			palette_guess_t g;
			if (expected_indices.size() == 0) begin
				report($sformatf("unexpected result with index %0d", got));
			end else begin
				g = expected_indices.pop_front();
				if (got !== g.index)
					report($sformatf("pixel %h background %0b: expected index %0d, got %0d",
						g.pixel, g.bg, g.index, got));
			end
		endtask

		function int pending();
			return expected_indices.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [23:0]      pixel_rgb;
	logic             background_only;
	logic             done;
	logic [IDX_W-1:0] palette_index;

	palette_scoreboard sb = new();
	int idle_cycles = 0;

	nearest_vga_palette_color i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.pixel_rgb       (pixel_rgb),
		.background_only (background_only),
		.done            (done),
		.palette_index   (palette_index)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Both sides are sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_pixel(pixel_rgb, background_only);
			if (done)
				sb.check_index(palette_index);
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_pixel(input logic [23:0] pix, input logic bg);
		start <= 1'b1;
		pixel_rgb <= pix;
		background_only <= bg;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		pixel_rgb <= 24'($urandom);
		background_only <= 1'($urandom);
		repeat (cycles) @(negedge clk);
	endtask

	initial begin
		logic [23:0] pix;
		int burst_left;
		int kind;
		int entry;
		int comp;
		logic [23:0] directed [8];

		directed = '{
			24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'h000055, 24'h005500, 24'h7F7F7F
		};
		arst_n = 1'b0;
		start = 1'b0;
		pixel_rgb = '0;
		background_only = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Extremes, equal-distance pixels and every palette entry itself.
		foreach (directed[i])
			send_pixel(directed[i], 1'(i));
		send_pixel(24'hFFFFFF, 1'b1);
		for (int i = 0; i < 16; i++)
			send_pixel(sb.vga_colors[i], 1'(i >> 2));
		pause_sender(3);

		burst_left = 0;
		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				pix = 24'($urandom);
			end else if (kind < 8) begin
				entry = $urandom_range(0, 15);
				pix = sb.vga_colors[entry];
				for (int c = 0; c < 3; c++) begin
					comp = int'(pix[c*8 +: 8]) + $urandom_range(0, 16) - 8;
					if (comp < 0)
						comp = 0;
					if (comp > 255)
						comp = 255;
					pix[c*8 +: 8] = 8'(comp);
				end
			end else begin
				// Components drawn near the palette levels and their midpoints.
				for (int c = 0; c < 3; c++)
					pix[c*8 +: 8] = 8'(42 * $urandom_range(0, 6) + $urandom_range(0, 1));
			end
			send_pixel(pix, 1'($urandom));
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0)
					pause_sender($urandom_range(1, 7));
			end else begin
				burst_left--;
			end
		end
		pause_sender(1);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
